/* hdl/blfmc_pkg.sv */
// ----------------------------------------------------------------------------
// blfmc_pkg
// Shared types, constants and helpers of the balance line-follow controller.
// ----------------------------------------------------------------------------
package blfmc_pkg;

	// defaults of the top-level parameters
	localparam int LINE_WIDTH_DEF    = 128;
	localparam int STEER_DIVISOR_DEF = 10;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_THRESHOLD = 3'd0,
		REG_GAIN_ANGLE     = 3'd1,
		REG_GAIN_RATE      = 3'd2,
		REG_GAIN_DISTANCE  = 3'd3,
		REG_GAIN_SPEED     = 3'd4,
		REG_SPEED_TARGET   = 3'd5
	} cfg_idx_t;

	// register reset values
	localparam logic [7:0]         DARK_THRESHOLD_RST = 8'd100;
	localparam logic signed [15:0] GAIN_ANGLE_RST     = 16'sd2560;
	localparam logic signed [15:0] GAIN_RATE_RST      = 16'sd2560;
	localparam logic signed [15:0] GAIN_DISTANCE_RST  = -16'sd5120;
	localparam logic signed [15:0] GAIN_SPEED_RST     = -16'sd2560;
	localparam logic signed [15:0] SPEED_TARGET_RST   = 16'sd77;

	// item kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Q8.8 gains used by the back end
	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] rate;
		logic signed [15:0] distance;
		logic signed [15:0] speed;
	} gains_t;

	// one tick record between front and back end
	typedef struct packed {
		logic signed [31:0] angle_sum;
		logic signed [31:0] distance_sum;
		logic signed [15:0] rate;
		logic signed [15:0] speed;
		logic        [7:0]  middle;
	} tick_rec_t;

	// saturate a 34-bit signed sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// saturate a 36-bit signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -36'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

/* hdl/blfmc_if.sv */
// ----------------------------------------------------------------------------
// blfmc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface blfmc_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic        [7:0]  pixel_col;
	logic        [7:0]  pixel_value;
	logic signed [15:0] gyro_rate;
	logic signed [15:0] wheel_speed;

	modport source (output valid, req_type, pixel_col, pixel_value, gyro_rate, wheel_speed,
		input ready);
	modport sink (input valid, req_type, pixel_col, pixel_value, gyro_rate, wheel_speed,
		output ready);
endinterface

interface blfmc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] motor_left;
	logic signed [15:0] motor_right;
	logic        [7:0]  line_middle;

	modport source (output valid, motor_left, motor_right, line_middle, input ready);
	modport sink (input valid, motor_left, motor_right, line_middle, output ready);
endinterface

/* hdl/balance_line_follow_motor_ctrl.sv */
// ----------------------------------------------------------------------------
// balance_line_follow_motor_ctrl
// Line-following balance controller: edge tracking, angle and distance
// accumulation, drive and steering mix to two saturated motor commands.
// ----------------------------------------------------------------------------
// path: a tick item passes the queue, the product and adder tree registers and the
//   motor mix into the output register; pixel items give no result
// throughput: one item per cycle while the queue is not full, set by the front end and
//   a fully pipelined back end; the back end stalls only while the output register waits
// reset: arst_n clears sums, edges (right edge to line width minus one), queue and
//   pipeline valids, and loads the configuration registers with their defaults
module balance_line_follow_motor_ctrl #(
	parameter int LINE_WIDTH    = blfmc_pkg::LINE_WIDTH_DEF,
	parameter int STEER_DIVISOR = blfmc_pkg::STEER_DIVISOR_DEF,
	parameter int QUEUE_DEPTH   = blfmc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	blfmc_in_if.sink                         in_ch,
	blfmc_out_if.source                      out_ch,
	input  logic                             cfg_we,
	input  logic [blfmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blfmc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [7:0]          dark_threshold_q;
	logic signed [15:0]  speed_target_q;
	blfmc_pkg::gains_t   gains_q;

	// queue between front and back end
	logic                 q_push;
	logic                 q_pop;
	logic                 q_empty;
	logic                 q_full;
	blfmc_pkg::tick_rec_t q_in;
	blfmc_pkg::tick_rec_t q_out;

	// register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_threshold_q <= blfmc_pkg::DARK_THRESHOLD_RST;
			gains_q.angle    <= blfmc_pkg::GAIN_ANGLE_RST;
			gains_q.rate     <= blfmc_pkg::GAIN_RATE_RST;
			gains_q.distance <= blfmc_pkg::GAIN_DISTANCE_RST;
			gains_q.speed    <= blfmc_pkg::GAIN_SPEED_RST;
			speed_target_q   <= blfmc_pkg::SPEED_TARGET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				blfmc_pkg::REG_DARK_THRESHOLD: dark_threshold_q <= cfg_data[7:0];
				blfmc_pkg::REG_GAIN_ANGLE:     gains_q.angle    <= cfg_data;
				blfmc_pkg::REG_GAIN_RATE:      gains_q.rate     <= cfg_data;
				blfmc_pkg::REG_GAIN_DISTANCE:  gains_q.distance <= cfg_data;
				blfmc_pkg::REG_GAIN_SPEED:     gains_q.speed    <= cfg_data;
				blfmc_pkg::REG_SPEED_TARGET:   speed_target_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end: edge tracking and saturating sums, one item per cycle while the queue is not full
	blfmc_front #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.dark_threshold (dark_threshold_q),
		.speed_target   (speed_target_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_in)
	);

	// tick records wait here while the output side stalls
	blfmc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back end: weighted sum, steering divide and motor mix
	blfmc_back #(
		.LINE_WIDTH    (LINE_WIDTH),
		.STEER_DIVISOR (STEER_DIVISOR)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.gains   (gains_q),
		.q_empty (q_empty),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

/* hdl/blfmc_front.sv */
// ----------------------------------------------------------------------------
// blfmc_front
// Accepts items; pixels update the edge registers, ticks update the sums, reset the
// edges and push a record to the queue.
// ----------------------------------------------------------------------------
module blfmc_front #(
	parameter int LINE_WIDTH = blfmc_pkg::LINE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	blfmc_in_if.sink                in_ch,
	input  logic [7:0]              dark_threshold,
	input  logic signed [15:0]      speed_target,
	input  logic                    q_full,
	output logic                    q_push,
	output blfmc_pkg::tick_rec_t    q_data
);

	localparam int         HALF   = LINE_WIDTH / 2;
	localparam logic [7:0] HALF8  = 8'(HALF);
	localparam logic [7:0] LAST8  = 8'(LINE_WIDTH - 1);
	localparam logic [9:0] WIDTH10 = 10'(LINE_WIDTH);

	logic               [7:0]  left_edge_q;
	logic               [7:0]  right_edge_q;
	logic signed        [31:0] angle_sum_q;
	logic signed        [31:0] distance_sum_q;

	logic                      accept;
	logic                      is_tick;
	logic                      dark;
	logic                      left_hit;
	logic                      right_hit;
	logic signed        [33:0] angle_wide;
	logic signed        [33:0] dist_wide;
	logic signed        [31:0] angle_next;
	logic signed        [31:0] dist_next;
	logic               [8:0]  edge_sum;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_tick     = (in_ch.req_type == blfmc_pkg::REQ_TICK);

	always_comb begin
		dark      = in_ch.pixel_value < dark_threshold;
		left_hit  = dark && (in_ch.pixel_col != 8'd0) && (in_ch.pixel_col <= HALF8)
			&& (in_ch.pixel_col > left_edge_q);
		right_hit = dark && (in_ch.pixel_col >= HALF8)
			&& (({2'b00, in_ch.pixel_col} + 10'd2) <= WIDTH10)
			&& (in_ch.pixel_col < right_edge_q);

		angle_wide = 34'(angle_sum_q) + 34'(in_ch.gyro_rate);
		dist_wide  = 34'(distance_sum_q) + 34'(in_ch.wheel_speed) - 34'(speed_target);
		angle_next = blfmc_pkg::sat32(angle_wide);
		dist_next  = blfmc_pkg::sat32(dist_wide);
		edge_sum   = {1'b0, left_edge_q} + {1'b0, right_edge_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q    <= '0;
			right_edge_q   <= LAST8;
			angle_sum_q    <= '0;
			distance_sum_q <= '0;
		end else if (accept) begin
			if (is_tick) begin
				angle_sum_q    <= angle_next;
				distance_sum_q <= dist_next;
				left_edge_q    <= '0;
				right_edge_q   <= LAST8;
			end else begin
				if (left_hit) begin
					left_edge_q <= in_ch.pixel_col;
				end
				if (right_hit) begin
					right_edge_q <= in_ch.pixel_col;
				end
			end
		end
	end

	assign q_push              = accept && is_tick;
	assign q_data.angle_sum    = angle_next;
	assign q_data.distance_sum = dist_next;
	assign q_data.rate         = in_ch.gyro_rate;
	assign q_data.speed        = in_ch.wheel_speed;
	assign q_data.middle       = edge_sum[8:1];

endmodule

/* hdl/blfmc_queue.sv */
// ----------------------------------------------------------------------------
// blfmc_queue
// Short flip-flop queue of tick records between front and back end.
// ----------------------------------------------------------------------------
module blfmc_queue #(
	parameter int DEPTH = blfmc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  blfmc_pkg::tick_rec_t push_data,
	input  logic                 pop,
	output blfmc_pkg::tick_rec_t pop_data,
	output logic                 empty,
	output logic                 full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	blfmc_pkg::tick_rec_t   entry_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_FULL);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/blfmc_back.sv */
// ----------------------------------------------------------------------------
// blfmc_back
// Drive and steering pipeline: products, adder tree, motor mix and output
// register.
// ----------------------------------------------------------------------------
module blfmc_back #(
	parameter int LINE_WIDTH    = blfmc_pkg::LINE_WIDTH_DEF,
	parameter int STEER_DIVISOR = blfmc_pkg::STEER_DIVISOR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  blfmc_pkg::gains_t    gains,
	input  logic                 q_empty,
	input  blfmc_pkg::tick_rec_t q_data,
	output logic                 q_pop,
	blfmc_out_if.source          out_ch
);

	localparam logic signed [8:0] HALF9 = 9'(LINE_WIDTH / 2);
	// ceil(2^16 / divisor), exact quotient for 8-bit magnitudes
	localparam logic [16:0] RECIP = 17'((65536 + STEER_DIVISOR - 1) / STEER_DIVISOR);

	logic advance;

	// stage 1
	logic               valid_s1;
	logic signed [47:0] p_angle_s1;
	logic signed [31:0] p_rate_s1;
	logic signed [47:0] p_dist_s1;
	logic signed [31:0] p_speed_s1;
	logic signed [8:0]  steer_s1;
	logic        [7:0]  middle_s1;

	// stage 2
	logic               valid_s2;
	logic signed [48:0] sum_a_s2;
	logic signed [48:0] sum_b_s2;
	logic signed [8:0]  steer_s2;
	logic        [7:0]  middle_s2;

	// stage 3
	logic               valid_s3;
	logic signed [49:0] acc_s3;
	logic signed [8:0]  steer_s3;
	logic        [7:0]  middle_s3;

	// output register
	logic               out_valid_q;
	logic signed [15:0] motor_left_q;
	logic signed [15:0] motor_right_q;
	logic        [7:0]  line_middle_q;

	logic signed [8:0]  diff;
	logic        [7:0]  mag;
	logic        [24:0] quot_prod;
	logic        [7:0]  quot;
	logic signed [8:0]  steer;
	logic               round_up;
	logic signed [34:0] drive;
	logic signed [35:0] left_w;
	logic signed [35:0] right_w;

	assign advance = !out_valid_q || out_ch.ready;
	assign q_pop   = advance && !q_empty;

	// steering: (middle - half) / divisor, truncated toward zero
	always_comb begin
		diff      = $signed({1'b0, q_data.middle}) - HALF9;
		mag       = diff[8] ? 8'(-diff) : diff[7:0];
		quot_prod = 25'(mag) * 25'(RECIP);
		quot      = quot_prod[23:16];
		steer     = diff[8] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	end

	// drive = acc / 65536 toward zero, then motor mix
	always_comb begin
		round_up = acc_s3[49] && (acc_s3[15:0] != 16'd0);
		drive    = 35'($signed(acc_s3[49:16])) + $signed({34'd0, round_up});
		left_w   = 36'(steer_s3) - 36'(drive);
		right_w  = -36'(steer_s3) - 36'(drive);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= !q_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_angle_s1    <= gains.angle * q_data.angle_sum;
			p_rate_s1     <= gains.rate * q_data.rate;
			p_dist_s1     <= gains.distance * q_data.distance_sum;
			p_speed_s1    <= gains.speed * q_data.speed;
			steer_s1      <= steer;
			middle_s1     <= q_data.middle;

			sum_a_s2      <= 49'(p_angle_s1) + 49'(p_rate_s1);
			sum_b_s2      <= 49'(p_dist_s1) + 49'(p_speed_s1);
			steer_s2      <= steer_s1;
			middle_s2     <= middle_s1;

			acc_s3        <= 50'(sum_a_s2) + 50'(sum_b_s2);
			steer_s3      <= steer_s2;
			middle_s3     <= middle_s2;

			motor_left_q  <= blfmc_pkg::sat16(left_w);
			motor_right_q <= blfmc_pkg::sat16(right_w);
			line_middle_q <= middle_s3;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.motor_left  = motor_left_q;
	assign out_ch.motor_right = motor_right_q;
	assign out_ch.line_middle = line_middle_q;

endmodule

/* hdl/blfmc_checker.sv */
// ----------------------------------------------------------------------------
// blfmc_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module blfmc_checker #(
	parameter int LINE_WIDTH = blfmc_pkg::LINE_WIDTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_req_type,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [15:0] motor_left,
	input logic signed [15:0] motor_right,
	input logic        [7:0]  line_middle
);

	localparam logic [8:0] LAST9 = 9'(LINE_WIDTH - 1);

	logic [7:0] pending_q;
	logic       tick_in;
	logic       res_out;

	assign tick_in = in_valid && in_ready && (in_req_type == blfmc_pkg::REQ_TICK);
	assign res_out = out_valid && out_ready;

	// ticks accepted whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (tick_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !tick_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 8'd0))
		else $error("result shown with no tick outstanding");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 8'd0) |-> in_ready)
		else $error("input stalled with nothing in flight");

	a_middle_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, line_middle} <= LAST9))
		else $error("line middle beyond line width");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(motor_left)
			&& $stable(motor_right) && $stable(line_middle)))
		else $error("stalled result dropped or changed");

endmodule

bind balance_line_follow_motor_ctrl blfmc_checker #(
	.LINE_WIDTH (LINE_WIDTH)
) u_blfmc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_req_type (in_ch.req_type),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.motor_left  (out_ch.motor_left),
	.motor_right (out_ch.motor_right),
	.line_middle (out_ch.line_middle)
);
